// ===== hdl/llss_pkg.sv =====
package llss_pkg;

   localparam int SERVER_SLOTS_DEF    = 8;
   localparam int KEYS_PER_SERVER_DEF = 64;

   typedef enum logic [2:0] {
      KIND_ADD_SERVER = 3'd0,
      KIND_DEL_SERVER = 3'd1,
      KIND_ADD_KEY    = 3'd2,
      KIND_DEL_KEY    = 3'd3,
      KIND_FIND_LEAST = 3'd4,
      KIND_QUERY      = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_UNKNOWN    = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_KEYS_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] server_id;
      logic [31:0] client_key;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] chosen_server;
      logic [6:0]  client_count;
   } rsp_type;

endpackage

// ===== hdl/least_loaded_server_selector_unit.sv =====
// An event scans every server slot, then for key insert or remove walks the slot's key entries
// (one key-store read per cycle), and when a server is added clears its key entries (one per
// cycle) before the result is offered.
// Throughput: one event at a time; the next is accepted the cycle after the result is taken.
// Every search step walks one slot through the shared slot comparator or one key entry through the key compare.
// Reset is synchronous: all slots become invalid with zero counts, and the unit idles.
module least_loaded_server_selector_unit #(
   parameter int SERVER_SLOTS    = llss_pkg::SERVER_SLOTS_DEF,
   parameter int KEYS_PER_SERVER = llss_pkg::KEYS_PER_SERVER_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  llss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output llss_pkg::rsp_type rsp_data
);
   import llss_pkg::*;

   localparam int SW = (SERVER_SLOTS > 1) ? $clog2(SERVER_SLOTS) : 1;
   localparam int KW = (KEYS_PER_SERVER > 1) ? $clog2(KEYS_PER_SERVER) : 1;
   localparam int ENTRIES = SERVER_SLOTS * KEYS_PER_SERVER;
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(KEYS_PER_SERVER + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SLOT, S_DECIDE, S_KEY, S_KEYLAST, S_FINISH, S_CLEAR, S_RESP
   } state_type;

   state_type state_ff;
   req_type   req_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic [SW:0] sidx_ff;
   logic [KW:0] kidx_ff;

   // Slot table in flip-flops.
   logic [SERVER_SLOTS-1:0] slot_valid_ff;
   logic [31:0]             slot_server_ff [SERVER_SLOTS];
   logic [CW-1:0]           slot_count_ff  [SERVER_SLOTS];

   // Search results.
   logic          hit_ff, free_ff, khit_ff, kfree_ff;
   logic [SW-1:0] hit_slot_ff, free_slot_ff;
   logic [KW-1:0] khit_at_ff, kfree_at_ff;

   // Key store: values and valid bits in memories. A slot's entries are cleared
   // when its server is added, so valid bits are only checked after being written.
   logic [31:0]       key_mem [ENTRIES];
   logic              key_vld_mem [ENTRIES];
   logic [31:0]       key_rd_ff;
   logic              key_rd_valid_ff;
   logic [KW-1:0]     key_rd_at_ff;

   logic [SW-1:0] scur;
   logic [AW-1:0] base, rd_addr, clr_base, kwr_addr;
   logic          kwr_en, kwr_valid;
   logic          eq_id, better;
   logic [6:0]    sat_cnt;

   assign scur = sidx_ff[SW-1:0];
   assign base = AW'(hit_slot_ff) * AW'(KEYS_PER_SERVER);
   assign clr_base = AW'(free_slot_ff) * AW'(KEYS_PER_SERVER);
   assign rd_addr = base + AW'(kidx_ff[KW-1:0]);

   // Shared compare unit, one slot per cycle.
   assign eq_id = slot_valid_ff[scur] && (slot_server_ff[scur] == req_ff.server_id);
   assign better = slot_valid_ff[scur] && (!hit_ff ||
                   (slot_count_ff[scur] < slot_count_ff[hit_slot_ff]) ||
                   ((slot_count_ff[scur] == slot_count_ff[hit_slot_ff]) &&
                    (slot_server_ff[scur] < slot_server_ff[hit_slot_ff])));
   assign sat_cnt = (32'(slot_count_ff[hit_slot_ff]) > 32'd127) ? 7'd127
                    : 7'(slot_count_ff[hit_slot_ff]);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   // Key store write port: clearing pass, key insert or key remove.
   always_comb begin
      kwr_en    = 1'b0;
      kwr_valid = 1'b0;
      kwr_addr  = rd_addr;
      if (state_ff == S_CLEAR) begin
         kwr_en   = 1'b1;
         kwr_addr = clr_base + AW'(kidx_ff[KW-1:0]);
      end else if (state_ff == S_FINISH && hit_ff) begin
         if (req_ff.kind == KIND_ADD_KEY && !khit_ff && kfree_ff) begin
            kwr_en    = 1'b1;
            kwr_valid = 1'b1;
            kwr_addr  = base + AW'(kfree_at_ff);
         end else if (req_ff.kind == KIND_DEL_KEY && khit_ff) begin
            kwr_en   = 1'b1;
            kwr_addr = base + AW'(khit_at_ff);
         end
      end
   end

   // Key store read and write.
   always_ff @(posedge clock) begin
      key_rd_ff       <= key_mem[rd_addr];
      key_rd_valid_ff <= key_vld_mem[rd_addr];
      key_rd_at_ff    <= kidx_ff[KW-1:0];
      if (kwr_en) begin
         key_vld_mem[kwr_addr] <= kwr_valid;
         if (kwr_valid) key_mem[kwr_addr] <= req_ff.client_key;
      end
   end

   // Result of the current event.
   always_comb begin
      rsp_in = '0;
      case (req_ff.kind)
         KIND_ADD_SERVER: begin
            if (!hit_ff && !free_ff) rsp_in.status = ST_TABLE_FULL;
         end
         KIND_DEL_SERVER, KIND_DEL_KEY: begin
            if (!hit_ff) rsp_in.status = ST_UNKNOWN;
         end
         KIND_ADD_KEY: begin
            if (!hit_ff) rsp_in.status = ST_UNKNOWN;
            else if (!khit_ff && !kfree_ff) rsp_in.status = ST_KEYS_FULL;
         end
         KIND_FIND_LEAST: begin
            if (!hit_ff) rsp_in.status = ST_UNKNOWN;
            else begin
               rsp_in.chosen_server = slot_server_ff[hit_slot_ff];
               rsp_in.client_count  = sat_cnt;
            end
         end
         KIND_QUERY: begin
            if (!hit_ff) rsp_in.status = ST_UNKNOWN;
            else rsp_in.client_count = sat_cnt;
         end
         default: ;
      endcase
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         for (int i = 0; i < SERVER_SLOTS; i++) slot_count_ff[i] <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff  <= req_data;
                  sidx_ff <= '0;
                  hit_ff  <= 1'b0;
                  free_ff <= 1'b0;
                  hit_slot_ff  <= '0;
                  free_slot_ff <= '0;
                  state_ff <= S_SLOT;
               end
            end
            S_SLOT: begin
               if (req_ff.kind == KIND_FIND_LEAST) begin
                  if (better) begin
                     hit_ff <= 1'b1;
                     hit_slot_ff <= scur;
                  end
               end else begin
                  if (eq_id && !hit_ff) begin
                     hit_ff <= 1'b1;
                     hit_slot_ff <= scur;
                  end
                  if (!slot_valid_ff[scur] && !free_ff) begin
                     free_ff <= 1'b1;
                     free_slot_ff <= scur;
                  end
               end
               sidx_ff <= sidx_ff + 1'b1;
               if (32'(sidx_ff) == SERVER_SLOTS - 1) state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               kidx_ff  <= '0;
               khit_ff  <= 1'b0;
               kfree_ff <= 1'b0;
               khit_at_ff  <= '0;
               kfree_at_ff <= '0;
               if ((req_ff.kind == KIND_ADD_KEY || req_ff.kind == KIND_DEL_KEY) && hit_ff)
                  state_ff <= S_KEY;
               else
                  state_ff <= S_FINISH;
            end
            S_KEY, S_KEYLAST: begin
               // Entry read last cycle is checked now.
               if (state_ff == S_KEYLAST || kidx_ff != '0) begin
                  if (key_rd_valid_ff) begin
                     if (key_rd_ff == req_ff.client_key && !khit_ff) begin
                        khit_ff <= 1'b1;
                        khit_at_ff <= key_rd_at_ff;
                     end
                  end else if (!kfree_ff) begin
                     kfree_ff <= 1'b1;
                     kfree_at_ff <= key_rd_at_ff;
                  end
               end
               if (state_ff == S_KEYLAST) state_ff <= S_FINISH;
               else begin
                  kidx_ff <= kidx_ff + 1'b1;
                  if (32'(kidx_ff) == KEYS_PER_SERVER - 1) state_ff <= S_KEYLAST;
               end
            end
            S_FINISH: begin
               rsp_ff <= rsp_in;
               // A newly added server gets its key entries cleared before the result.
               if (req_ff.kind == KIND_ADD_SERVER && !hit_ff && free_ff) begin
                  slot_valid_ff[free_slot_ff]  <= 1'b1;
                  slot_server_ff[free_slot_ff] <= req_ff.server_id;
                  slot_count_ff[free_slot_ff]  <= '0;
                  kidx_ff  <= '0;
                  state_ff <= S_CLEAR;
               end else begin
                  state_ff <= S_RESP;
               end
               case (req_ff.kind)
                  KIND_DEL_SERVER: begin
                     if (hit_ff) begin
                        slot_valid_ff[hit_slot_ff] <= 1'b0;
                        slot_count_ff[hit_slot_ff] <= '0;
                     end
                  end
                  KIND_ADD_KEY: begin
                     if (hit_ff && !khit_ff && kfree_ff)
                        slot_count_ff[hit_slot_ff] <= slot_count_ff[hit_slot_ff] + 1'b1;
                  end
                  KIND_DEL_KEY: begin
                     if (hit_ff && khit_ff)
                        slot_count_ff[hit_slot_ff] <= slot_count_ff[hit_slot_ff] - 1'b1;
                  end
                  default: ;
               endcase
            end
            S_CLEAR: begin
               kidx_ff <= kidx_ff + 1'b1;
               if (32'(kidx_ff) == KEYS_PER_SERVER - 1) state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
